// ===== rtl/bdf_pkg.sv =====
// shared types, constants and helpers of the button debounce state machine
package bdf_pkg;

   localparam int TIME_W    = 32;
   localparam int INIT_W    = 18;
   localparam int FINAL_W   = 18;
   localparam int POLL_W    = 20;
   localparam int BTN_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 20;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_INIT  = 2'd1,
      PH_POLL  = 2'd2,
      PH_FINAL = 2'd3
   } phase_type;

   typedef enum logic {
      OP_PRESS = 1'b0,
      OP_TICK  = 1'b1
   } opcode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_WAIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FINAL_WAIT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_INTERVAL = 2'd2;

   localparam logic [INIT_W-1:0]  INITIAL_WAIT_RESET  = 18'd200000;
   localparam logic [FINAL_W-1:0] FINAL_WAIT_RESET    = 18'd200000;
   localparam logic [POLL_W-1:0]  POLL_INTERVAL_RESET = 20'd20000;

   localparam logic [BTN_W-1:0] BTN_NONE = '0;

   typedef struct packed {
      logic [INIT_W-1:0]  initial_wait;
      logic [FINAL_W-1:0] final_wait;
      logic [POLL_W-1:0]  poll_interval;
   } cfg_type;

   typedef struct packed {
      logic              opcode;
      logic [TIME_W-1:0] now_us;
      logic [BTN_W-1:0]  button_code;
   } evt_type;

   typedef struct packed {
      logic [BTN_W-1:0] debounced_button;
      logic             press_armed;
      phase_type        phase;
   } result_type;

   function automatic logic wait_over(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] ref_time,
                                      input logic [TIME_W-1:0] duration);
      logic [TIME_W-1:0] elapsed;
      elapsed = now - ref_time;
      return elapsed >= duration;
   endfunction

endpackage

// ===== rtl/bdf_csr.sv =====
// configuration registers of the button debounce state machine
module bdf_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bdf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdf_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output bdf_pkg::cfg_type                  cfg
);
   import bdf_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_wait  <= INITIAL_WAIT_RESET;
         cfg_ff.final_wait    <= FINAL_WAIT_RESET;
         cfg_ff.poll_interval <= POLL_INTERVAL_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INITIAL_WAIT:  cfg_ff.initial_wait  <= csr_wdata[INIT_W-1:0];
            CSR_FINAL_WAIT:    cfg_ff.final_wait    <= csr_wdata[FINAL_W-1:0];
            CSR_POLL_INTERVAL: cfg_ff.poll_interval <= csr_wdata[POLL_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/bdf_fsm.sv =====
// debounce phase machine: phase, held button and reference time
module bdf_fsm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  bdf_pkg::evt_type     evt,
   input  bdf_pkg::cfg_type     cfg,
   output bdf_pkg::result_type  result
);
   import bdf_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BTN_W-1:0]  held_ff, held_in;
   logic [TIME_W-1:0] ref_ff, ref_in;
   logic [TIME_W-1:0] duration;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= BTN_NONE;
         ref_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         ref_ff   <= ref_in;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_INIT:  duration = TIME_W'(cfg.initial_wait);
         PH_FINAL: duration = TIME_W'(cfg.final_wait);
         default:  duration = TIME_W'(cfg.poll_interval);
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      ref_in   = ref_ff;
      if (evt.opcode == OP_PRESS) begin
         if (phase_ff == PH_IDLE && evt.button_code != BTN_NONE) begin
            phase_in = PH_INIT;
            held_in  = evt.button_code;
            ref_in   = evt.now_us;
         end
      end else begin
         case (phase_ff)
            PH_INIT: begin
               if (wait_over(evt.now_us, ref_ff, duration)) begin
                  phase_in = PH_POLL;
                  ref_in   = evt.now_us;
               end
            end
            PH_POLL: begin
               if (wait_over(evt.now_us, ref_ff, duration)) begin
                  ref_in = evt.now_us;
                  if (evt.button_code != held_ff) begin
                     held_in  = evt.button_code;
                     phase_in = PH_FINAL;
                  end
               end
            end
            PH_FINAL: begin
               if (wait_over(evt.now_us, ref_ff, duration)) begin
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
      result.debounced_button = held_in;
      result.press_armed      = (phase_in == PH_IDLE);
      result.phase            = phase_in;
   end

endmodule

// ===== rtl/button_debounce_fsm.sv =====
// button debounce state machine top level: input register, phase machine, result register
// Takes one item per clock cycle when the result side keeps up; each accepted item is held
// in the input register until the result side is free, then the phase machine updates and
// the result register loads at the same edge. The rate is set by the update of the phase,
// held button and reference time, which closes through one 32-bit subtract and compare. A
// press item (opcode 0) is honored only while the block is idle; tick items (opcode 1)
// advance the initial wait, polling and final wait phases. Every item returns exactly one
// result holding the state after that item. Configuration writes are always accepted and
// take effect at once; write them only while no item is in flight.
module button_debounce_fsm (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [bdf_pkg::TIME_W-1:0]      req_now_us,
   input  logic [bdf_pkg::BTN_W-1:0]       req_button_code,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bdf_pkg::BTN_W-1:0]       rsp_debounced_button,
   output logic                            rsp_press_armed,
   output logic [1:0]                      rsp_phase,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bdf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bdf_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import bdf_pkg::*;

   cfg_type    cfg;
   evt_type    evt_ff;
   logic       evt_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       fire;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = evt_valid_ff && out_free;
   assign req_ready = !evt_valid_ff || fire;

   bdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdf_fsm u_fsm (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .evt    (evt_ff),
      .cfg    (cfg),
      .result (result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         evt_valid_ff <= 1'b0;
      end else if (req_ready) begin
         evt_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         evt_ff.opcode      <= req_opcode;
         evt_ff.now_us      <= req_now_us;
         evt_ff.button_code <= req_button_code;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_debounced_button = rsp_ff.debounced_button;
   assign rsp_press_armed      = rsp_ff.press_armed;
   assign rsp_phase            = rsp_ff.phase;

`ifndef SYNTH
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed item did not reach the result register");

   a_armed_matches_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_press_armed == (rsp_phase == PH_IDLE)))
      else $error("press_armed disagrees with phase");

   a_press_starts_wait: assert property (@(posedge clock) disable iff (reset)
      (fire && evt_ff.opcode == OP_PRESS && evt_ff.button_code != BTN_NONE
       && rsp_valid && rsp_phase == PH_IDLE && rsp_ready)
      |=> (rsp_phase == PH_INIT && rsp_debounced_button == $past(evt_ff.button_code)))
      else $error("press while idle did not start the initial wait");

   a_input_held_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (evt_valid_ff && !out_free) |=> (evt_valid_ff && $stable(evt_ff)))
      else $error("input register changed while the result side stalled");
`endif

endmodule
